[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/prq_pkg.sv]
// ----------------------------------------------------------------------------
// prq_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int NAME_LIMIT = 8192;

    localparam int TAG_W     = 16;
    localparam int LEN_W     = 13;
    localparam int SIZE_W    = 32;
    localparam int ENTRY_W   = TAG_W + LEN_W + SIZE_W;
    localparam int POLICY_W  = 2;
    localparam int CAP_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic [POLICY_W-1:0] POLICY_FIFO = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_NAME = 2'd1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b1;

    localparam logic [POLICY_W-1:0] POLICY_RESET   = POLICY_FIFO;
    localparam logic [CAP_W-1:0]    CAPACITY_RESET = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_SHIFT_START,
        ST_SHIFT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic ready;
        logic accept;
        logic decode;
        logic scan;
        logic shift_start;
        logic shift;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_insert;
        logic queue_full;
        logic queue_empty;
        logic scan_done;
        logic shift_needed;
        logic shift_done;
        logic out_free;
    } t_dp_status;

endpackage

[sv/prq_ram.sv]
// ----------------------------------------------------------------------------
// prq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module prq_ram #(
    parameter int WIDTH = 61,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/prq_ctrl.sv]
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer for decode, key scan, compaction and result hand-off.
// ----------------------------------------------------------------------------
module prq_ctrl
    import prq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (!i_status.is_insert && !i_status.queue_empty) n_state = ST_SCAN;
                else n_state = ST_FINISH;
            end
            ST_SCAN: begin
                if (i_status.scan_done) n_state = ST_SHIFT_START;
            end
            ST_SHIFT_START: begin
                if (i_status.shift_needed) n_state = ST_SHIFT;
                else n_state = ST_FINISH;
            end
            ST_SHIFT: begin
                if (i_status.shift_done) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.ready  = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_DECODE:      o_cmd.decode      = 1'b1;
            ST_SCAN:        o_cmd.scan        = 1'b1;
            ST_SHIFT_START: o_cmd.shift_start = 1'b1;
            ST_SHIFT:       o_cmd.shift       = 1'b1;
            ST_FINISH:      o_cmd.finish      = i_status.out_free;
            default:        o_cmd = '0;
        endcase
    end

endmodule

[sv/prq_datapath.sv]
// ----------------------------------------------------------------------------
// prq_datapath
// Request latch, entry store, min-key scan, compaction and result register.
// ----------------------------------------------------------------------------
module prq_datapath
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl_cmd            i_cmd,
    output t_dp_status           o_status,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    input  logic                 i_in_command,
    input  logic [TAG_W-1:0]     i_in_tag,
    input  logic [LEN_W-1:0]     i_in_name_length,
    input  logic [SIZE_W-1:0]    i_in_file_size,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [STATUS_W-1:0]  o_out_status,
    output logic [TAG_W-1:0]     o_out_tag,
    output logic [LEN_W-1:0]     o_out_name_length,
    output logic [SIZE_W-1:0]    o_out_file_size,
    output logic [OCC_W-1:0]     o_out_occupancy
);

    logic [POLICY_W-1:0] r_policy;
    logic [CAP_W-1:0]    r_capacity;
    logic [CW-1:0]       r_count,    n_count;
    logic                r_cmd,      n_cmd;
    logic [ENTRY_W-1:0]  r_req,      n_req;
    logic [STATUS_W-1:0] r_code,     n_code;
    logic [CW-1:0]       r_ptr,      n_ptr;
    logic [AW-1:0]       r_best_idx, n_best_idx;
    logic [ENTRY_W-1:0]  r_best,     n_best;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [ENTRY_W-1:0]  r_out_entry,  n_out_entry;
    logic [OCC_W-1:0]    r_out_occ,    n_out_occ;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [LEN_W-1:0]   sat_len;
    logic               queue_full;
    logic               smaller;
    logic [CW-1:0]      next_idx;
    logic [CW-1:0]      shift_dst;
    logic [CW-1:0]      count_upd;

    prq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // entry word: tag lowest, then name length, then file size
    assign sat_len = (32'(i_in_name_length) > NAME_LIMIT - 1) ?
                     LEN_W'(NAME_LIMIT - 1) : i_in_name_length;

    assign queue_full = (32'(r_count) >= 32'(r_capacity)) ||
                        (32'(r_count) >= QUEUE_DEPTH);

    always_comb begin
        case (r_policy)
            POLICY_FIFO: smaller = 1'b0;
            POLICY_NAME: smaller = ram_rdata[TAG_W +: LEN_W] < r_best[TAG_W +: LEN_W];
            default:     smaller = ram_rdata[TAG_W+LEN_W +: SIZE_W] <
                                   r_best[TAG_W+LEN_W +: SIZE_W];
        endcase
    end

    assign next_idx  = CW'(r_best_idx) + CW'(1);
    assign shift_dst = r_ptr - CW'(2);
    assign count_upd = (r_code != STATUS_OK) ? r_count :
                       (r_cmd == CMD_INSERT) ? r_count + CW'(1) : r_count - CW'(1);

    always_comb begin
        o_status.is_insert    = (r_cmd == CMD_INSERT);
        o_status.queue_full   = queue_full;
        o_status.queue_empty  = (r_count == '0);
        o_status.scan_done    = (r_ptr == r_count) || (r_policy == POLICY_FIFO);
        o_status.shift_needed = (next_idx < r_count);
        o_status.shift_done   = (r_ptr == r_count);
        o_status.out_free     = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_count      = r_count;
        n_cmd        = r_cmd;
        n_req        = r_req;
        n_code       = r_code;
        n_ptr        = r_ptr;
        n_best_idx   = r_best_idx;
        n_best       = r_best;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        n_out_occ    = r_out_occ;
        ram_we       = 1'b0;
        ram_waddr    = r_count[AW-1:0];
        ram_wdata    = r_req;
        ram_raddr    = '0;

        if (i_cmd.accept) begin
            n_cmd = i_in_command;
            n_req = {i_in_file_size, sat_len, i_in_tag};
        end

        if (i_cmd.decode) begin
            n_best     = '0;
            n_best_idx = '0;
            if (r_cmd == CMD_INSERT) begin
                n_code = queue_full ? STATUS_FULL : STATUS_OK;
                ram_we = !queue_full;
            end else begin
                n_code = (r_count == '0) ? STATUS_EMPTY : STATUS_OK;
                n_ptr  = CW'(1);
            end
        end

        if (i_cmd.scan) begin
            if ((r_ptr == CW'(1)) || smaller) begin
                n_best     = ram_rdata;
                n_best_idx = AW'(r_ptr - CW'(1));
            end
            if (!o_status.scan_done) begin
                ram_raddr = r_ptr[AW-1:0];
                n_ptr     = r_ptr + CW'(1);
            end
        end

        if (i_cmd.shift_start) begin
            ram_raddr = next_idx[AW-1:0];
            n_ptr     = next_idx + CW'(1);
        end

        if (i_cmd.shift) begin
            ram_we    = 1'b1;
            ram_waddr = shift_dst[AW-1:0];
            ram_wdata = ram_rdata;
            if (!o_status.shift_done) begin
                ram_raddr = r_ptr[AW-1:0];
                n_ptr     = r_ptr + CW'(1);
            end
        end

        if (i_cmd.finish) begin
            n_out_valid  = 1'b1;
            n_out_status = r_code;
            n_out_entry  = r_best;
            n_out_occ    = OCC_W'(count_upd);
            n_count      = count_upd;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= POLICY_RESET;
            r_capacity  <= CAPACITY_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POLICY:   r_policy   <= i_cfg_wdata[POLICY_W-1:0];
                    CFG_CAPACITY: r_capacity <= i_cfg_wdata[CAP_W-1:0];
                    default: ;
                endcase
            end
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_req        <= n_req;
        r_code       <= n_code;
        r_ptr        <= n_ptr;
        r_best_idx   <= n_best_idx;
        r_best       <= n_best;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
        r_out_occ    <= n_out_occ;
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_status      = r_out_status;
    assign o_out_tag         = r_out_entry[0 +: TAG_W];
    assign o_out_name_length = r_out_entry[TAG_W +: LEN_W];
    assign o_out_file_size   = r_out_entry[TAG_W+LEN_W +: SIZE_W];
    assign o_out_occupancy   = r_out_occ;

endmodule

[sv/policy_request_queue_core.sv]
// ----------------------------------------------------------------------------
// policy_request_queue_core
// Bounded request queue served first-in-first-out, shortest name first or
// smallest file first.
// ----------------------------------------------------------------------------
// One request is handled at a time, and the input is ready again once its
// result is loaded into the output register, in the same cycle that the
// result becomes valid. An insert, and a remove that fails, go from decode
// straight to the hand-off. A remove from a non-empty queue first scans the
// keys for the chosen entry (first-in-first-out skips the scan) and then
// closes up the gap behind the removed entry: the entry RAM has one read
// port and is read once per cycle, first to scan the keys and then to shift
// the later entries down. A result that the sink has not taken stalls only
// the final hand-off.
`include "assert_macros.svh"

module policy_request_queue_core
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tag, name_length, file_size, zero pad
    input  logic [63:0]          s_axis_tdata,
    // command
    input  logic [0:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_tag, out_name_length, out_file_size, occupancy, zero pad
    output logic [71:0]          m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]  m_axis_tuser
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    logic [TAG_W-1:0]    w_out_tag;
    logic [LEN_W-1:0]    w_out_len;
    logic [SIZE_W-1:0]   w_out_size;
    logic [OCC_W-1:0]    w_out_occ;
    logic [STATUS_W-1:0] w_out_status;

    prq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    prq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_command      (s_axis_tuser[0]),
        .i_in_tag          (s_axis_tdata[15:0]),
        .i_in_name_length  (s_axis_tdata[28:16]),
        .i_in_file_size    (s_axis_tdata[60:29]),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_out_status      (w_out_status),
        .o_out_tag         (w_out_tag),
        .o_out_name_length (w_out_len),
        .o_out_file_size   (w_out_size),
        .o_out_occupancy   (w_out_occ)
    );

    assign s_axis_tready = w_cmd.ready;
    assign m_axis_tuser  = w_out_status;
    assign m_axis_tdata  = {6'd0, w_out_occ, w_out_size, w_out_len, w_out_tag};

    // one request in flight at a time
    `ASSERT_NEXT(a_single_request, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // failed steps carry no entry
    `ASSERT_IMPL(a_fail_no_entry, i_clk, i_rst_n, m_axis_tvalid && (w_out_status != STATUS_OK), (w_out_tag == '0) && (w_out_len == '0) && (w_out_size == '0))
    // empty status only with an empty queue
    `ASSERT_IMPL(a_empty_occ, i_clk, i_rst_n, m_axis_tvalid && (w_out_status == STATUS_EMPTY), w_out_occ == '0)
    // occupancy never beyond the store
    `ASSERT_IMPL(a_occ_bound, i_clk, i_rst_n, m_axis_tvalid, 32'(w_out_occ) <= QUEUE_DEPTH)

endmodule

[dv/prq_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prq_checker
// Watches the request and result streams and the register writes of the
// request queue. It keeps its own copy of the queue and the policy
// registers, works out the result of every accepted request, and compares
// each delivered result field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module prq_checker
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // tag, name_length, file_size, zero pad
    input  logic [63:0]          s_axis_tdata,
    // command
    input  logic [0:0]           s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_tag, out_name_length, out_file_size, occupancy, zero pad
    input  logic [71:0]          m_axis_tdata,
    // status
    input  logic [STATUS_W-1:0]  m_axis_tuser,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic [LEN_W-1:0]    len;
        logic [SIZE_W-1:0]   size;
        logic [OCC_W-1:0]    occ;
    } t_result;

    t_entry              held_entries [QUEUE_DEPTH];
    int unsigned         held_count;
    logic [POLICY_W-1:0] service_policy;
    logic [CAP_W-1:0]    queue_capacity;
    t_result             owed_results [$];
    int                  mismatch_count = 0;

    function automatic t_result serve_request(input logic cmd, input t_entry req);
        t_result     res;
        int unsigned limit;
        int unsigned pick;
        res        = '0;
        res.status = STATUS_OK;
        if (cmd == CMD_INSERT) begin
            limit = (queue_capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : queue_capacity;
            if (held_count >= limit) begin
                res.status = STATUS_FULL;
            end else begin
                held_entries[held_count] = req;
                held_count++;
            end
        end else if (held_count == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            pick = 0;
            if (service_policy != POLICY_FIFO) begin
                for (int i = 1; i < held_count; i++) begin
                    if (service_policy == POLICY_NAME ?
                            held_entries[i].len < held_entries[pick].len :
                            held_entries[i].size < held_entries[pick].size) begin
                        pick = i;
                    end
                end
            end
            res.tag  = held_entries[pick].tag;
            res.len  = held_entries[pick].len;
            res.size = held_entries[pick].size;
            for (int i = pick; i + 1 < held_count; i++) begin
                held_entries[i] = held_entries[i + 1];
            end
            held_count--;
        end
        res.occ = held_count[OCC_W-1:0];
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_entry  req;
        t_result want;
        if (!i_rst_n) begin
            service_policy = POLICY_RESET;
            queue_capacity = CAPACITY_RESET;
            held_count     = 0;
            owed_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POLICY:   service_policy = i_cfg_wdata[POLICY_W-1:0];
                    CFG_CAPACITY: queue_capacity = i_cfg_wdata[CAP_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req.tag  = s_axis_tdata[0 +: TAG_W];
                req.len  = s_axis_tdata[TAG_W +: LEN_W];
                req.size = s_axis_tdata[TAG_W + LEN_W +: SIZE_W];
                owed_results.push_back(serve_request(s_axis_tuser[0], req));
            end
            if ($isunknown(m_axis_tvalid)) begin
                $error("m_axis_tvalid: expected 0x0 or 0x1, actual 0x%0h", m_axis_tvalid);
                mismatch_count++;
            end else if (m_axis_tvalid && m_axis_tready) begin
                if (owed_results.size() == 0) begin
                    $error("result: expected none, actual 0x%0h", m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = owed_results.pop_front();
                    compare_field("status", 64'(want.status), 64'(m_axis_tuser));
                    compare_field("out_tag", 64'(want.tag),
                                  64'(m_axis_tdata[0 +: TAG_W]));
                    compare_field("out_name_length", 64'(want.len),
                                  64'(m_axis_tdata[TAG_W +: LEN_W]));
                    compare_field("out_file_size", 64'(want.size),
                                  64'(m_axis_tdata[TAG_W + LEN_W +: SIZE_W]));
                    compare_field("occupancy", 64'(want.occ),
                                  64'(m_axis_tdata[TAG_W + LEN_W + SIZE_W +: OCC_W]));
                end
            end
        end
        o_pending    <= owed_results.size();
        o_fail_count <= mismatch_count;
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for policy_request_queue_core. A short directed run
// covers empty and full queues, key ties, every policy code and the capacity
// corner cases; random phases then mix inserts and removes under changing
// policy and capacity, with bursty requests, a stalling sink and two long
// sink hold-offs. Checking is done by prq_checker.
// ----------------------------------------------------------------------------
module tb_top
    import prq_pkg::*;
();

    localparam logic [POLICY_W-1:0] POLICY_SIZE  = 2'd2;
    localparam logic [POLICY_W-1:0] POLICY_SPARE = 2'd3;
    localparam int PHASES          = 12;
    localparam int PHASE_REQUESTS  = 130;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 1000000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [71:0]          m_axis_tdata;
    logic [STATUS_W-1:0]  m_axis_tuser;

    int fail_count;
    int pending_count;
    int cycle_count     = 0;
    int hold_off_asked  = 0;
    int hold_off_served = 0;

    logic [POLICY_W-1:0] phase_policy [PHASES] = '{
        POLICY_FIFO, POLICY_NAME, POLICY_SIZE, POLICY_SPARE, POLICY_NAME, POLICY_FIFO,
        POLICY_SIZE, POLICY_NAME, POLICY_SPARE, POLICY_FIFO, POLICY_SIZE, POLICY_NAME
    };
    int phase_capacity [PHASES] = '{16, 31, 1, 0, 17, 3, 16, 2, 31, 8, 5, 16};
    int phase_insert_pct [PHASES] = '{70, 60, 50, 60, 80, 40, 55, 65, 75, 30, 50, 20};

    policy_request_queue_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    prq_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL policy_request_queue_core");
            $finish;
        end
    end

    task automatic send_request(input logic cmd, input logic [TAG_W-1:0] tag,
                                input logic [LEN_W-1:0] len,
                                input logic [SIZE_W-1:0] size);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, size, len, tag};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [POLICY_W-1:0] pol, input logic [CAP_W-1:0] cap);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_POLICY;
        i_cfg_wdata <= CFG_DAT_W'(pol);
        @(posedge i_clk);
        i_cfg_index <= CFG_CAPACITY;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // sink: stretches of steady, patchy and sparse acceptance, plus long hold-offs
    initial begin
        int mode;
        int stretch;
        mode    = 0;
        stretch = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_asked != hold_off_served) begin
                hold_off_served = hold_off_asked;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            if (stretch == 0) begin
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(8, 80);
            end
            stretch--;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    initial begin
        int                  burst_left;
        int                  gap;
        logic                cmd;
        logic [TAG_W-1:0]    tag;
        logic [LEN_W-1:0]    len;
        logic [SIZE_W-1:0]   size;
        logic [CAP_W-1:0]    cap;
        burst_left = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_POLICY;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_INSERT;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue, field extremes, arrival order
        send_request(CMD_REMOVE, 16'hffff, 13'h1fff, 32'hffffffff);
        send_request(CMD_INSERT, 16'h0000, 13'h0000, 32'h00000000);
        send_request(CMD_INSERT, 16'hffff, 13'h1fff, 32'hffffffff);
        send_request(CMD_INSERT, 16'h1234, 13'd5, 32'd100);
        send_request(CMD_REMOVE, '0, '0, '0);

        // shortest name, tie goes to the earlier arrival
        set_config(POLICY_NAME, 5'd16);
        send_request(CMD_INSERT, 16'h0002, 13'd5, 32'd50);
        send_request(CMD_REMOVE, '0, '0, '0);
        send_request(CMD_REMOVE, '0, '0, '0);

        // smallest file with a tie
        set_config(POLICY_SIZE, 5'd16);
        send_request(CMD_INSERT, 16'h0003, 13'd0, 32'd7);
        send_request(CMD_INSERT, 16'h0004, 13'd9, 32'd7);
        send_request(CMD_REMOVE, '0, '0, '0);
        send_request(CMD_REMOVE, '0, '0, '0);

        // spare policy code behaves as smallest file, small capacity fills up
        set_config(POLICY_SPARE, 5'd2);
        send_request(CMD_INSERT, 16'h0005, 13'd1, 32'd0);
        send_request(CMD_INSERT, 16'h0006, 13'd1, 32'd0);
        send_request(CMD_REMOVE, '0, '0, '0);

        // zero capacity rejects every insert
        set_config(POLICY_FIFO, 5'd0);
        send_request(CMD_INSERT, 16'h0007, 13'd2, 32'd2);
        send_request(CMD_REMOVE, '0, '0, '0);
        send_request(CMD_REMOVE, '0, '0, '0);

        // capacity lowered below occupancy
        set_config(POLICY_FIFO, 5'd31);
        send_request(CMD_INSERT, 16'h0008, 13'd30, 32'd3);
        send_request(CMD_INSERT, 16'h0009, 13'd20, 32'd2);
        send_request(CMD_INSERT, 16'h000a, 13'd10, 32'd1);
        set_config(POLICY_NAME, 5'd1);
        send_request(CMD_INSERT, 16'h000b, 13'd0, 32'd0);
        send_request(CMD_REMOVE, '0, '0, '0);
        send_request(CMD_REMOVE, '0, '0, '0);
        send_request(CMD_INSERT, 16'h000c, 13'd0, 32'd0);
        send_request(CMD_REMOVE, '0, '0, '0);

        for (int p = 0; p < PHASES; p++) begin
            cap = (p == PHASES - 1) ? CAP_W'($urandom_range(0, 31)) :
                                      CAP_W'(phase_capacity[p]);
            set_config(phase_policy[p], cap);
            if (p == 4 || p == 8) begin
                hold_off_asked++;
            end
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    if (gap != 0) begin
                        s_axis_tvalid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                burst_left--;
                cmd  = ($urandom_range(0, 99) < phase_insert_pct[p]) ? CMD_INSERT : CMD_REMOVE;
                tag  = TAG_W'($urandom);
                len  = $urandom_range(0, 1) ? LEN_W'($urandom_range(0, 7)) : LEN_W'($urandom);
                size = $urandom_range(0, 1) ? SIZE_W'($urandom_range(0, 7)) : $urandom;
                send_request(cmd, tag, len, size);
            end
        end

        wait_idle();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS policy_request_queue_core");
        end else begin
            $display("FAIL policy_request_queue_core");
        end
        $finish;
    end

endmodule

[policy_request_queue_core.f]
+incdir+sv
sv/prq_pkg.sv
sv/prq_ram.sv
sv/prq_ctrl.sv
sv/prq_datapath.sv
sv/policy_request_queue_core.sv
dv/prq_checker.sv
dv/tb_top.sv
